FILE: rtl/dtq_pkg.sv
package dtq_pkg;

    localparam int FUNC_W = 2;
    localparam int TASK_W = 4;
    localparam int DELAY_W = 32;
    localparam int STATUS_W = 3;

    // Result words of one input word are held in a small buffer.
    localparam int MAX_RES = 16;
    localparam int RES_IW = 4;
    localparam int RES_CW = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_POP    = 2'd2,
        FN_TICK   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_ABSENT  = 3'd1,
        ST_DUP     = 3'd2,
        ST_WOKEN   = 3'd3,
        ST_NOWAKE  = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input word
        logic walk_start;  // point the walk at the head
        logic walk_step;   // subtract current delta, move to next
        logic do_insert;   // link the new task ahead of the walk position
        logic do_unlink;   // unlink the target task
        logic sel_head;    // target the head task
        logic tick_dec;    // saturating decrement of the head delta
        logic res_store;   // record a result in the result buffer
        logic [STATUS_W-1:0] res_status;
        logic res_use_head; // result task is the head, else the input task
        logic res_zero;     // result task is zero
        logic [RES_IW-1:0] res_idx; // result buffer slot to write or read
    } dtq_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic in_range;
        logic is_queued;
        logic nonempty;
        logic walk_have;
        logic walk_more;   // remaining delay exceeds the current delta
        logic head_zero;
    } dtq_stat_t;

endpackage

FILE: rtl/dtq_datapath.sv
module dtq_datapath #(
    parameter int MAX_TASKS = 16,
    parameter int TICK_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [dtq_pkg::FUNC_W-1:0]    in_func,
    input  logic [dtq_pkg::TASK_W-1:0]    in_task,
    input  logic [dtq_pkg::DELAY_W-1:0]   in_delay,
    input  dtq_pkg::dtq_cmd_t             cmd,
    output dtq_pkg::dtq_stat_t            stat,
    output logic [dtq_pkg::STATUS_W-1:0]  res_status,
    output logic [dtq_pkg::TASK_W-1:0]    res_task,
    output logic [dtq_pkg::DELAY_W-1:0]   head_rem
);
    import dtq_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic [IW-1:0]        nxt_reg [MAX_TASKS];
    logic [IW-1:0]        prv_reg [MAX_TASKS];
    logic                 hn_reg  [MAX_TASKS];
    logic                 hp_reg  [MAX_TASKS];
    logic [TICK_BITS-1:0] dl_reg  [MAX_TASKS];
    logic [MAX_TASKS-1:0] queued_reg;
    logic [IW-1:0]        head_reg, tail_reg;
    logic                 ne_reg;

    logic [FUNC_W-1:0]    func_reg;
    logic [TASK_W-1:0]    task_reg;
    logic [TICK_BITS-1:0] rem_reg;
    logic [IW-1:0]        cur_reg;
    logic                 have_reg;

    logic [TASK_W-1:0]    rbuf_reg [MAX_RES];
    logic [STATUS_W-1:0]  rst_reg;

    logic                 in_range;
    logic [IW-1:0]        tgt;
    logic [IW-1:0]        tix;
    logic [TICK_BITS-1:0] dcur;
    logic [TASK_W-1:0]    res_src;

    assign in_range = ({{(32-TASK_W){1'b0}}, task_reg} < 32'(MAX_TASKS));
    assign tix  = IW'(task_reg);
    assign tgt  = cmd.sel_head ? head_reg : tix;
    assign dcur = dl_reg[cur_reg];

    assign stat.func      = func_reg;
    assign stat.in_range  = in_range;
    assign stat.is_queued = in_range && queued_reg[tix];
    assign stat.nonempty  = ne_reg;
    assign stat.walk_have = have_reg;
    assign stat.walk_more = rem_reg > dcur;
    assign stat.head_zero = (dl_reg[head_reg] == '0);

    assign res_src    = cmd.res_zero ? '0 : (cmd.res_use_head ? TASK_W'(head_reg) : task_reg);
    assign res_task   = rbuf_reg[cmd.res_idx];
    assign res_status = rst_reg;
    assign head_rem   = ne_reg ? DELAY_W'(dl_reg[head_reg]) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queued_reg <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            ne_reg     <= 1'b0;
        end else begin
            if (cmd.load) begin
                func_reg <= in_func;
                task_reg <= in_task;
                rem_reg  <= TICK_BITS'(in_delay);
            end
            if (cmd.walk_start) begin
                cur_reg  <= head_reg;
                have_reg <= ne_reg;
            end
            if (cmd.walk_step) begin
                rem_reg  <= rem_reg - dcur;
                have_reg <= hn_reg[cur_reg];
                cur_reg  <= nxt_reg[cur_reg];
            end
            if (cmd.res_store) begin
                rbuf_reg[cmd.res_idx] <= res_src;
                rst_reg               <= cmd.res_status;
            end
            if (cmd.tick_dec && dl_reg[head_reg] != '0) begin
                dl_reg[head_reg] <= dl_reg[head_reg] - 1'b1;
            end
            if (cmd.do_insert) begin
                if (have_reg) begin
                    hp_reg[tix]  <= hp_reg[cur_reg];
                    prv_reg[tix] <= prv_reg[cur_reg];
                    if (hp_reg[cur_reg]) begin
                        nxt_reg[prv_reg[cur_reg]] <= tix;
                        hn_reg[prv_reg[cur_reg]]  <= 1'b1;
                    end else begin
                        head_reg <= tix;
                    end
                    prv_reg[cur_reg] <= tix;
                    hp_reg[cur_reg]  <= 1'b1;
                    nxt_reg[tix]     <= cur_reg;
                    hn_reg[tix]      <= 1'b1;
                    dl_reg[cur_reg]  <= dcur - rem_reg;
                end else if (ne_reg) begin
                    nxt_reg[tail_reg] <= tix;
                    hn_reg[tail_reg]  <= 1'b1;
                    prv_reg[tix]      <= tail_reg;
                    hp_reg[tix]       <= 1'b1;
                    hn_reg[tix]       <= 1'b0;
                    tail_reg          <= tix;
                end else begin
                    head_reg <= tix;
                    tail_reg <= tix;
                    hn_reg[tix] <= 1'b0;
                    hp_reg[tix] <= 1'b0;
                    ne_reg   <= 1'b1;
                end
                dl_reg[tix]     <= rem_reg;
                queued_reg[tix] <= 1'b1;
            end
            if (cmd.do_unlink) begin
                if (hp_reg[tgt]) begin
                    nxt_reg[prv_reg[tgt]] <= nxt_reg[tgt];
                    hn_reg[prv_reg[tgt]]  <= hn_reg[tgt];
                end else begin
                    head_reg <= nxt_reg[tgt];
                    ne_reg   <= hn_reg[tgt];
                end
                if (hn_reg[tgt]) begin
                    dl_reg[nxt_reg[tgt]]  <= dl_reg[nxt_reg[tgt]] + dl_reg[tgt];
                    prv_reg[nxt_reg[tgt]] <= prv_reg[tgt];
                    hp_reg[nxt_reg[tgt]]  <= hp_reg[tgt];
                end else begin
                    tail_reg <= prv_reg[tgt];
                end
                hn_reg[tgt]     <= 1'b0;
                hp_reg[tgt]     <= 1'b0;
                queued_reg[tgt] <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/dtq_ctrl.sv
module dtq_ctrl #(
    parameter int MAX_TASKS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    output logic                in_ready,
    input  dtq_pkg::dtq_stat_t  stat,
    output dtq_pkg::dtq_cmd_t   cmd,
    output logic                res_valid,
    output logic                res_last,
    input  logic                res_taken
);
    import dtq_pkg::*;

    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_WALK, S_WAKE, S_OUT
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     steps_reg;
    logic [RES_CW-1:0] cnt_reg;
    logic [RES_CW-1:0] out_reg;
    logic              walk_go;
    logic              wake_go;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res_last  = (out_reg == cnt_reg - 1'b1);

    assign walk_go = stat.walk_have && stat.walk_more && steps_reg < CW'(MAX_TASKS);
    // Leading tasks whose delta is zero wake, one per cycle, up to MAX_RES per tick.
    assign wake_go = stat.nonempty && stat.head_zero && cnt_reg < RES_CW'(MAX_RES);

    always_comb begin
        cmd = '0;
        cmd.load = in_fire;
        cmd.res_idx = out_reg[RES_IW-1:0];
        unique case (state_reg)
            S_IDLE: begin
            end
            S_DECODE: begin
                cmd.walk_start = 1'b1;
                cmd.res_idx = '0;
                unique case (func_t'(stat.func))
                    FN_INSERT: begin
                        if (!stat.in_range) begin
                            cmd.res_store  = 1'b1;
                            cmd.res_status = ST_ABSENT;
                        end else if (stat.is_queued) begin
                            cmd.res_store  = 1'b1;
                            cmd.res_status = ST_DUP;
                        end
                    end
                    FN_REMOVE: begin
                        cmd.res_store  = 1'b1;
                        cmd.do_unlink  = stat.is_queued;
                        cmd.res_status = stat.is_queued ? ST_DONE : ST_ABSENT;
                    end
                    FN_POP: begin
                        cmd.res_store = 1'b1;
                        if (stat.nonempty) begin
                            cmd.do_unlink    = 1'b1;
                            cmd.sel_head     = 1'b1;
                            cmd.res_use_head = 1'b1;
                            cmd.res_status   = ST_DONE;
                        end else begin
                            cmd.res_zero   = 1'b1;
                            cmd.res_status = ST_ABSENT;
                        end
                    end
                    FN_TICK: begin
                        cmd.tick_dec = stat.nonempty;
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                cmd.res_idx = '0;
                if (walk_go) begin
                    cmd.walk_step = 1'b1;
                end else begin
                    cmd.do_insert  = 1'b1;
                    cmd.res_store  = 1'b1;
                    cmd.res_status = ST_DONE;
                end
            end
            S_WAKE: begin
                cmd.res_idx = cnt_reg[RES_IW-1:0];
                if (wake_go) begin
                    cmd.do_unlink    = 1'b1;
                    cmd.sel_head     = 1'b1;
                    cmd.res_use_head = 1'b1;
                    cmd.res_store    = 1'b1;
                    cmd.res_status   = ST_WOKEN;
                end else begin
                    cmd.res_zero   = 1'b1;
                    cmd.res_store  = (cnt_reg == '0);
                    cmd.res_status = ST_NOWAKE;
                end
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            steps_reg <= '0;
            cnt_reg   <= '0;
            out_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) state_reg <= S_DECODE;
                end
                S_DECODE: begin
                    steps_reg <= '0;
                    out_reg   <= '0;
                    cnt_reg   <= (stat.func == FN_TICK) ? '0 : RES_CW'(1);
                    if (stat.func == FN_TICK) begin
                        state_reg <= S_WAKE;
                    end else if (stat.func == FN_INSERT && stat.in_range && !stat.is_queued) begin
                        state_reg <= S_WALK;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_WALK: begin
                    if (walk_go) begin
                        steps_reg <= steps_reg + 1'b1;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_WAKE: begin
                    if (wake_go) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end else begin
                        if (cnt_reg == '0) cnt_reg <= RES_CW'(1);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (res_taken) begin
                        if (res_last) state_reg <= S_IDLE;
                        else out_reg <= out_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/delta_timer_queue_unit.sv
// Flow: remove, pop and a rejected insert go from decode straight to the output state;
// an insert first walks k entries (at most MAX_TASKS) and then links the task; a tick
// gives its words after waking w tasks, and shows them one per cycle while m_tready is high.
// Throughput: one word at a time; the next word is accepted in the cycle after the last
// result is taken, so an insert with a long walk holds off the next word.
// Reset: aresetn is synchronous and active low; it empties the queue at once.
module delta_timer_queue_unit #(
    parameter int MAX_TASKS = 16,
    parameter int TICK_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[1:0], task_id[5:2], delay_ticks[37:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[2:0], task_out[6:3], head_remaining[38:7]
    output logic        m_tlast
);
    import dtq_pkg::*;

    dtq_cmd_t  cmd;
    dtq_stat_t stat;
    logic      in_fire;
    logic      res_taken;
    logic [STATUS_W-1:0] res_status;
    logic [TASK_W-1:0]   res_task;
    logic [DELAY_W-1:0]  head_rem;

    assign in_fire   = s_tvalid && s_tready;
    assign res_taken = m_tvalid && m_tready;

    dtq_datapath #(.MAX_TASKS(MAX_TASKS), .TICK_BITS(TICK_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_func(s_tdata[1:0]), .in_task(s_tdata[5:2]), .in_delay(s_tdata[37:6]),
        .cmd(cmd), .stat(stat), .res_status(res_status), .res_task(res_task),
        .head_rem(head_rem)
    );

    dtq_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(in_fire), .in_ready(s_tready),
        .stat(stat), .cmd(cmd), .res_valid(m_tvalid), .res_last(m_tlast),
        .res_taken(res_taken)
    );

    // The queue does not change while results are shown, so the word stays stable.
    assign m_tdata = {1'b0, head_rem, res_task, res_status};

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result word changed while waiting");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready) else $error("second word accepted while busy");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input ready while a result is shown");

endmodule

FILE: test/tb_delta_timer_queue_unit.sv
`timescale 1ns / 100ps

module tb_delta_timer_queue_unit;
    import dtq_pkg::*;

    localparam int NTASK = 16;
    localparam int RANDOM_WORDS = 90;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        status_t     status;
        logic [3:0]  task_out;
        logic [31:0] head_rem;
        logic        last;
    } wake_word_t;

    typedef struct {
        func_t       fn;
        logic [3:0]  tid;
        logic [31:0] dly;
        logic        typed;     // expected first result given in the row
        status_t     st;
        logic [3:0]  tk;
        logic [31:0] hr;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // Predictor copy of the delta list.
    logic [3:0]  q_next [NTASK];
    logic [3:0]  q_prev [NTASK];
    logic        q_hasn [NTASK];
    logic        q_hasp [NTASK];
    logic [31:0] q_delta [NTASK];
    logic        q_on [NTASK];
    logic [3:0]  q_head;
    logic [3:0]  q_tail;
    logic        q_full;

    wake_word_t  pending_words[$];
    int          errors;
    longint      cycles;
    int          words_sent;
    int          words_seen;
    int          src_idle_pct;
    int          snk_idle_pct;

    delta_timer_queue_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int queued_count();
        int n;
        n = 0;
        for (int i = 0; i < NTASK; i++) n += q_on[i];
        return n;
    endfunction

    function automatic void unlink_entry(logic [3:0] t);
        logic [3:0] p;
        logic [3:0] n;
        p = q_prev[t];
        n = q_next[t];
        if (q_hasp[t]) begin
            q_next[p] = n;
            q_hasn[p] = q_hasn[t];
        end else begin
            q_head = n;
            q_full = q_hasn[t];
        end
        if (q_hasn[t]) begin
            q_delta[n] = q_delta[n] + q_delta[t];
            q_prev[n] = p;
            q_hasp[n] = q_hasp[t];
        end else begin
            q_tail = p;
        end
        q_hasn[t] = 1'b0;
        q_hasp[t] = 1'b0;
        q_on[t] = 1'b0;
    endfunction

    function automatic void link_entry(logic [3:0] t, logic [31:0] d);
        logic [3:0] cur;
        logic [3:0] p;
        logic       have;
        int         steps;
        cur = q_head;
        have = q_full;
        steps = 0;
        while (have && d > q_delta[cur] && steps < NTASK) begin
            d -= q_delta[cur];
            have = q_hasn[cur];
            cur = q_next[cur];
            steps++;
        end
        if (have) begin
            p = q_prev[cur];
            q_hasp[t] = q_hasp[cur];
            q_prev[t] = p;
            if (q_hasp[cur]) begin
                q_next[p] = t;
                q_hasn[p] = 1'b1;
            end else begin
                q_head = t;
            end
            q_prev[cur] = t;
            q_hasp[cur] = 1'b1;
            q_next[t] = cur;
            q_hasn[t] = 1'b1;
            q_delta[cur] = q_delta[cur] - d;
        end else if (q_full) begin
            q_next[q_tail] = t;
            q_hasn[q_tail] = 1'b1;
            q_prev[t] = q_tail;
            q_hasp[t] = 1'b1;
            q_hasn[t] = 1'b0;
            q_tail = t;
        end else begin
            q_head = t;
            q_tail = t;
            q_hasn[t] = 1'b0;
            q_hasp[t] = 1'b0;
            q_full = 1'b1;
        end
        q_delta[t] = d;
        q_on[t] = 1'b1;
    endfunction

    // Applies one command word to the list and queues the words it should produce.
    function automatic void predict_wakeups(func_t fn, logic [3:0] tid, logic [31:0] dly);
        status_t    st[$];
        logic [3:0] tk[$];
        logic [3:0] h;
        logic [31:0] hr;
        wake_word_t w;
        case (fn)
            FN_INSERT: begin
                if (q_on[tid]) begin
                    st.push_back(ST_DUP);
                end else begin
                    link_entry(tid, dly);
                    st.push_back(ST_DONE);
                end
                tk.push_back(tid);
            end
            FN_REMOVE: begin
                if (!q_on[tid]) begin
                    st.push_back(ST_ABSENT);
                end else begin
                    unlink_entry(tid);
                    st.push_back(ST_DONE);
                end
                tk.push_back(tid);
            end
            FN_POP: begin
                if (!q_full) begin
                    st.push_back(ST_ABSENT);
                    tk.push_back(4'd0);
                end else begin
                    h = q_head;
                    unlink_entry(h);
                    st.push_back(ST_DONE);
                    tk.push_back(h);
                end
            end
            default: begin
                if (q_full) begin
                    if (q_delta[q_head] != 0) q_delta[q_head] = q_delta[q_head] - 1;
                    while (q_full && st.size() < NTASK && q_delta[q_head] == 0) begin
                        h = q_head;
                        unlink_entry(h);
                        st.push_back(ST_WOKEN);
                        tk.push_back(h);
                    end
                end
                if (st.size() == 0) begin
                    st.push_back(ST_NOWAKE);
                    tk.push_back(4'd0);
                end
            end
        endcase
        hr = q_full ? q_delta[q_head] : 32'd0;
        foreach (st[i]) begin
            w.status = st[i];
            w.task_out = tk[i];
            w.head_rem = hr;
            w.last = (i == st.size() - 1);
            pending_words.push_back(w);
        end
    endfunction

    task automatic send_word(func_t fn, logic [3:0] tid, logic [31:0] dly);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, dly, tid, fn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_wakeups(fn, tid, dly);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(negedge aclk);
    endtask

    // Result side: random back-pressure and field-by-field comparison.
    always @(negedge aclk) begin
        if (aresetn) m_tready <= !(snk_idle_pct > 0 && $urandom_range(99) < snk_idle_pct);
    end

    always @(posedge aclk) begin
        wake_word_t exp_w;
        wake_word_t got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tdata[2:0]);
            got.task_out = m_tdata[6:3];
            got.head_rem = m_tdata[38:7];
            got.last = m_tlast;
            words_seen++;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
            end else begin
                exp_w = pending_words.pop_front();
                if (got.status !== exp_w.status) begin
                    $display("%0t: status expected %0d got %0d", $time, exp_w.status,
                             got.status);
                    errors++;
                end
                if (got.task_out !== exp_w.task_out) begin
                    $display("%0t: task_out expected %0d got %0d", $time, exp_w.task_out,
                             got.task_out);
                    errors++;
                end
                if (got.head_rem !== exp_w.head_rem) begin
                    $display("%0t: head_remaining expected %0d got %0d", $time,
                             exp_w.head_rem, got.head_rem);
                    errors++;
                end
                if (got.last !== exp_w.last) begin
                    $display("%0t: last expected %0b got %0b", $time, exp_w.last, got.last);
                    errors++;
                end
            end
        end
    end

    task automatic random_phase(int n);
        int         r;
        logic [3:0] t;
        logic [31:0] d;
        for (int i = 0; i < n; i++) begin
            r = int'($urandom_range(99));
            t = 4'($urandom_range(NTASK - 1));
            case ($urandom_range(3))
                0: d = $urandom_range(3);
                1: d = $urandom_range(12);
                2: d = $urandom;
                default: d = 32'hFFFF_FFFF - $urandom_range(2);
            endcase
            if (r < 40) send_word(FN_INSERT, t, d);
            else if (r < 55) send_word(FN_REMOVE, t, $urandom);
            else if (r < 65) send_word(FN_POP, t, $urandom);
            else send_word(FN_TICK, t, $urandom);
        end
    endtask

    dir_row_t dir_rows[$];

    function automatic dir_row_t mk(func_t fn, logic [3:0] tid, logic [31:0] dly,
                                    logic typed = 1'b0, status_t st = ST_DONE,
                                    logic [3:0] tk = 4'd0, logic [31:0] hr = 32'd0);
        dir_row_t r;
        r.fn = fn; r.tid = tid; r.dly = dly; r.typed = typed;
        r.st = st; r.tk = tk; r.hr = hr;
        return r;
    endfunction

    initial begin
        errors = 0;
        cycles = 0;
        words_sent = 0;
        words_seen = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        foreach (q_on[i]) begin
            q_on[i] = 1'b0; q_next[i] = '0; q_prev[i] = '0;
            q_hasn[i] = 1'b0; q_hasp[i] = 1'b0; q_delta[i] = '0;
        end
        q_head = '0; q_tail = '0; q_full = 1'b0;

        // Empty-queue cases, ties, extremes, duplicate, absent remove, saturating tick.
        dir_rows = {
            mk(FN_POP, 4'd0, 32'd0, 1'b1, ST_ABSENT, 4'd0, 32'd0),
            mk(FN_TICK, 4'd5, 32'd0, 1'b1, ST_NOWAKE, 4'd0, 32'd0),
            mk(FN_REMOVE, 4'd15, 32'd0, 1'b1, ST_ABSENT, 4'd15, 32'd0),
            mk(FN_INSERT, 4'd0, 32'hFFFF_FFFF, 1'b1, ST_DONE, 4'd0, 32'hFFFF_FFFF),
            mk(FN_INSERT, 4'd0, 32'd7, 1'b1, ST_DUP, 4'd0, 32'hFFFF_FFFF),
            mk(FN_INSERT, 4'd15, 32'd3),
            mk(FN_INSERT, 4'd7, 32'd3),
            mk(FN_INSERT, 4'd8, 32'd5),
            mk(FN_INSERT, 4'd9, 32'd0),
            mk(FN_INSERT, 4'd10, 32'hAAAA_5555),
            mk(FN_TICK, 4'd0, 32'd0),
            mk(FN_TICK, 4'd0, 32'd0),
            mk(FN_REMOVE, 4'd8, 32'd0),
            mk(FN_REMOVE, 4'd8, 32'd0),
            mk(FN_TICK, 4'd0, 32'd0),
            mk(FN_TICK, 4'd0, 32'd0),
            mk(FN_TICK, 4'd0, 32'd0),
            mk(FN_POP, 4'd3, 32'd0),
            mk(FN_INSERT, 4'd1, 32'd0),
            mk(FN_INSERT, 4'd2, 32'd0),
            mk(FN_TICK, 4'd0, 32'd0),
            mk(FN_POP, 4'd0, 32'd0),
            mk(FN_POP, 4'd0, 32'd0),
            mk(FN_POP, 4'd0, 32'd0, 1'b1, ST_ABSENT, 4'd0, 32'd0)
        };

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        m_tready <= 1'b1;

        // The block takes one word at a time, so right after acceptance the
        // queue holds only the results of that word.
        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].fn, dir_rows[i].tid, dir_rows[i].dly);
            if (dir_rows[i].typed && (pending_words[0].status !== dir_rows[i].st ||
                    pending_words[0].task_out !== dir_rows[i].tk ||
                    pending_words[0].head_rem !== dir_rows[i].hr)) begin
                $display("%0t: directed row %0d expected %0d/%0d/%0d predicted %p", $time,
                         i, dir_rows[i].st, dir_rows[i].tk, dir_rows[i].hr,
                         pending_words[0]);
                errors++;
            end
        end
        drain_results();

        src_idle_pct = 11; snk_idle_pct = 54;
        random_phase(RANDOM_WORDS / 3);
        // Fill the list so that long walks and multi-wake ticks occur.
        for (int t = 0; t < NTASK; t++) send_word(FN_INSERT, 4'(t), $urandom_range(2));
        send_word(FN_TICK, 4'd0, 32'd0);
        send_word(FN_TICK, 4'd0, 32'd0);
        src_idle_pct = 54; snk_idle_pct = 11;
        random_phase(RANDOM_WORDS / 3);
        src_idle_pct = 0; snk_idle_pct = 0;
        random_phase(RANDOM_WORDS / 3);
        drain_results();
        repeat (60) @(negedge aclk);

        $display("Sent %0d command words, checked %0d result words, %0d tasks left queued.",
                 words_sent, words_seen, queued_count());
        if (errors == 0 && pending_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
